FILE: src/rwla_pkg.sv
// ----------------------------------------------------------------------------
// rwla_pkg
// Shared types and constants for the reader/writer lock arbiter: operation
// and status codes, sequencer states, wait queue sizing and queue control.
// ----------------------------------------------------------------------------
package rwla_pkg;

    // Number of requesters, which is also the depth of each wait queue.
    localparam int NUM_REQUESTERS = 16;

    // Field widths fixed by the interface.
    localparam int ID_W     = 4;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int READER_W = 5;

    // Queue pointer and fill count widths follow from the depth.
    localparam int PTR_W = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;
    localparam int CNT_W = $clog2(NUM_REQUESTERS + 1);

    localparam logic [CNT_W-1:0]    QUEUE_FULL = CNT_W'(NUM_REQUESTERS);
    localparam logic [CNT_W-1:0]    CNT_ONE    = CNT_W'(1);
    localparam logic [PTR_W-1:0]    PTR_LAST   = PTR_W'(NUM_REQUESTERS - 1);
    localparam logic [READER_W-1:0] READER_TOP = READER_W'(31);

    // Request operations.
    typedef enum logic [OP_W-1:0] {
        OP_READ    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_UNLOCK  = 2'd2,
        OP_DESTROY = 2'd3
    } opcode_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED  = 2'd0,
        ST_QUEUED   = 2'd1,
        ST_RELEASED = 2'd2,
        ST_FAULT    = 2'd3
    } status_t;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_WGRANT,
        S_RGRANT,
        S_RDESTROY,
        S_WDESTROY
    } state_t;

    // Control of one wait queue: push, pop and clear.
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } queue_ctrl_t;

endpackage

FILE: src/rwla_queue.sv
// ----------------------------------------------------------------------------
// rwla_queue
// FIFO wait queue held in a synchronous memory with a registered read port.
// The read address is the next head pointer, so the registered read data
// is updated with the head pointer and shows the entry at the current head.
// ----------------------------------------------------------------------------
module rwla_queue
    import rwla_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  queue_ctrl_t       ctrl,
    input  logic [ID_W-1:0]   push_id,
    output logic [ID_W-1:0]   head_id,
    output logic [CNT_W-1:0]  count
);

    logic [ID_W-1:0]  mem [NUM_REQUESTERS];
    logic [ID_W-1:0]  head_id_reg;
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Pointer and fill count update; a clear overrides a pop in the same cycle.
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctrl.clear)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
        else
        begin
            if (ctrl.pop)
            begin
                head_next = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
            end
            if (ctrl.push)
            begin
                tail_next = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
            end
            if (ctrl.push && !ctrl.pop)
            begin
                count_next = count_reg + 1'b1;
            end
            else if (ctrl.pop && !ctrl.push)
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Memory write at the tail and registered read at the upcoming head.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail_reg] <= push_id;
        end
        head_id_reg <= mem[head_next];
    end

    assign head_id = head_id_reg;
    assign count   = count_reg;

endmodule

FILE: src/reader_writer_lock_arbiter.sv
// ----------------------------------------------------------------------------
// reader_writer_lock_arbiter
// Writer-preferring reader/writer lock with FIFO wait queues for readers
// and writers, kept in two small synchronous memories.
// ----------------------------------------------------------------------------
// A request is taken while the sequencer is idle, even if the previous result
// still sits in the output register. Its first result, which always concerns
// the issuer, is loaded into the output register from S_FIRST once that
// register is free; each further result (a grant or a destroy release for a
// waiter) comes from a grant or destroy state, which pops one queue entry per
// cycle while the output register is free, through the memory's single
// registered read port. The next request can be transferred in the cycle
// after the last result is loaded. No clearing pass runs after reset.
module reader_writer_lock_arbiter
    import rwla_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [OP_W-1:0]     opcode,
    input  logic [ID_W-1:0]     requester_id,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [ID_W-1:0]     target_id,
    output logic [STATUS_W-1:0] status,
    output logic [READER_W-1:0] readers_now,
    output logic                writer_holds,
    output logic                last
);

    state_t                state_reg;
    state_t                state_next;
    opcode_t               op_reg;
    logic [ID_W-1:0]       id_reg;
    logic [READER_W-1:0]   reader_count_reg;
    logic [READER_W-1:0]   reader_count_next;
    logic                  write_held_reg;
    logic                  write_held_next;

    logic                  out_valid_reg;
    logic [ID_W-1:0]       target_id_reg;
    status_t               status_reg;
    logic [READER_W-1:0]   readers_now_reg;
    logic                  writer_holds_reg;
    logic                  last_reg;

    logic                  out_free;
    logic                  emit;
    logic [ID_W-1:0]       emit_target;
    status_t               emit_status;
    logic                  emit_last;

    queue_ctrl_t           rq_ctrl;
    queue_ctrl_t           wq_ctrl;
    logic [ID_W-1:0]       rq_head;
    logic [ID_W-1:0]       wq_head;
    logic [CNT_W-1:0]      rq_count;
    logic [CNT_W-1:0]      wq_count;

    // Reader and writer wait queues.
    rwla_queue u_reader_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (rq_ctrl),
        .push_id (id_reg),
        .head_id (rq_head),
        .count   (rq_count)
    );

    rwla_queue u_writer_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (wq_ctrl),
        .push_id (id_reg),
        .head_id (wq_head),
        .count   (wq_count)
    );

    // The output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || out_ready;

    // Sequencer: next state, lock state update, queue control and result.
    always_comb
    begin
        state_next        = state_reg;
        reader_count_next = reader_count_reg;
        write_held_next   = write_held_reg;
        in_ready          = 1'b0;
        emit              = 1'b0;
        emit_target       = id_reg;
        emit_status       = ST_GRANTED;
        emit_last         = 1'b1;
        rq_ctrl           = '0;
        wq_ctrl           = '0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = S_FIRST;
                end
            end

            S_FIRST:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    case (op_reg)
                        OP_READ:
                        begin
                            if (write_held_reg || wq_count != '0)
                            begin
                                if (rq_count == QUEUE_FULL)
                                begin
                                    emit_status = ST_FAULT;
                                end
                                else
                                begin
                                    emit_status  = ST_QUEUED;
                                    rq_ctrl.push = 1'b1;
                                end
                            end
                            else if (reader_count_reg >= READER_TOP)
                            begin
                                emit_status = ST_FAULT;
                            end
                            else
                            begin
                                reader_count_next = reader_count_reg + 1'b1;
                            end
                        end

                        OP_WRITE:
                        begin
                            if (write_held_reg || reader_count_reg != '0)
                            begin
                                if (wq_count == QUEUE_FULL)
                                begin
                                    emit_status = ST_FAULT;
                                end
                                else
                                begin
                                    emit_status  = ST_QUEUED;
                                    wq_ctrl.push = 1'b1;
                                end
                            end
                            else
                            begin
                                write_held_next = 1'b1;
                            end
                        end

                        OP_UNLOCK:
                        begin
                            if (write_held_reg)
                            begin
                                if (wq_count != '0)
                                begin
                                    emit_last  = 1'b0;
                                    state_next = S_WGRANT;
                                end
                                else
                                begin
                                    write_held_next = 1'b0;
                                    if (rq_count != '0)
                                    begin
                                        emit_last  = 1'b0;
                                        state_next = S_RGRANT;
                                    end
                                end
                            end
                            else if (reader_count_reg != '0)
                            begin
                                reader_count_next = reader_count_reg - 1'b1;
                                if (reader_count_reg == READER_W'(1) && wq_count != '0)
                                begin
                                    emit_last  = 1'b0;
                                    state_next = S_WGRANT;
                                end
                            end
                            else
                            begin
                                emit_status = ST_FAULT;
                            end
                        end

                        OP_DESTROY:
                        begin
                            if (rq_count != '0)
                            begin
                                emit_last  = 1'b0;
                                state_next = S_RDESTROY;
                            end
                            else if (wq_count != '0)
                            begin
                                emit_last  = 1'b0;
                                state_next = S_WDESTROY;
                            end
                            else
                            begin
                                rq_ctrl.clear = 1'b1;
                                wq_ctrl.clear = 1'b1;
                            end
                        end

                        default:
                        begin
                            emit_status = ST_FAULT;
                        end
                    endcase
                end
            end

            // Hand the lock to the writer at the head of its queue.
            S_WGRANT:
            begin
                if (out_free)
                begin
                    emit            = 1'b1;
                    emit_target     = wq_head;
                    wq_ctrl.pop     = 1'b1;
                    write_held_next = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            // Grant every queued reader, one per cycle while the output register is free, saturating the count.
            S_RGRANT:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    emit_target = rq_head;
                    rq_ctrl.pop = 1'b1;
                    if (reader_count_reg < READER_TOP)
                    begin
                        reader_count_next = reader_count_reg + 1'b1;
                    end
                    emit_last = (rq_count == CNT_ONE);
                    if (rq_count == CNT_ONE)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            // Release queued readers on destroy, then move on to writers.
            S_RDESTROY:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    emit_target = rq_head;
                    emit_status = ST_RELEASED;
                    rq_ctrl.pop = 1'b1;
                    emit_last   = 1'b0;
                    if (rq_count == CNT_ONE)
                    begin
                        if (wq_count != '0)
                        begin
                            state_next = S_WDESTROY;
                        end
                        else
                        begin
                            emit_last     = 1'b1;
                            rq_ctrl.clear = 1'b1;
                            wq_ctrl.clear = 1'b1;
                            state_next    = S_IDLE;
                        end
                    end
                end
            end

            // Release queued writers on destroy and reset both queues at the end.
            S_WDESTROY:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    emit_target = wq_head;
                    emit_status = ST_RELEASED;
                    wq_ctrl.pop = 1'b1;
                    emit_last   = (wq_count == CNT_ONE);
                    if (wq_count == CNT_ONE)
                    begin
                        rq_ctrl.clear = 1'b1;
                        wq_ctrl.clear = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers: sequencer state, lock state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            reader_count_reg <= '0;
            write_held_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            reader_count_reg <= reader_count_next;
            write_held_reg   <= write_held_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture and result payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg <= opcode_t'(opcode);
            id_reg <= requester_id;
        end
        if (emit)
        begin
            target_id_reg    <= emit_target;
            status_reg       <= emit_status;
            readers_now_reg  <= reader_count_next;
            writer_holds_reg <= write_held_next;
            last_reg         <= emit_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign target_id    = target_id_reg;
    assign status       = status_reg;
    assign readers_now  = readers_now_reg;
    assign writer_holds = writer_holds_reg;
    assign last         = last_reg;

`ifndef NO_ASSERTIONS
    // The lock is never held by a writer and readers at once.
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        write_held_reg |-> (reader_count_reg == '0))
        else $error("lock write-held while readers are counted");

    // Between requests, waiting readers imply a writer holds or waits.
    a_readers_wait_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && rq_count != '0) |-> (write_held_reg || wq_count != '0))
        else $error("readers left waiting on an available lock");

    // Reader pop states only run while the reader queue holds entries.
    a_reader_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RGRANT || state_reg == S_RDESTROY) |-> (rq_count != '0))
        else $error("reader queue popped while empty");

    // The writer grant and release states only run with writers queued.
    a_writer_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WGRANT || state_reg == S_WDESTROY) |-> (wq_count != '0))
        else $error("writer queue popped while empty");
`endif

endmodule

FILE: test/tb_reader_writer_lock_arbiter.sv
// ----------------------------------------------------------------------------
// tb_reader_writer_lock_arbiter
// Self-checking bench for the reader/writer lock arbiter. A table of requests
// first takes the lock through its corner cases, some rows carrying their
// issuer result written out by hand. Random episodes of shared, exclusive
// and destroy traffic follow. The run ends by overflowing both wait queues
// and then driving the reader count to its ceiling. Every result transfer is
// compared, field by field, with a behavioural copy of the lock kept here.
// ----------------------------------------------------------------------------
module tb_reader_writer_lock_arbiter;
    timeunit 1ns;
    timeprecision 1ps;

    import rwla_pkg::*;

    localparam int RANDOM_ITEMS  = 10;
    localparam int LONG_HOLD     = 200;
    localparam int HOLD_AFTER    = 60;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int NUM_ROWS      = 24;

    // One result of the lock as it appears on the output ports.
    typedef struct packed {
        logic [ID_W-1:0]     target;
        status_t             st;
        logic [READER_W-1:0] readers;
        logic                held;
        logic                fin;
    } lock_result_t;

    // One row of the directed walk; want holds the issuer result where typed.
    typedef struct packed {
        opcode_t         op;
        logic [ID_W-1:0] id;
        logic            typed;
        lock_result_t    want;
    } stim_row_t;

    // Directed walk from reset: misuse, shared use, writer hand-over,
    // reader release, destroy with waiters and an empty destroy.
    localparam stim_row_t LOCK_WALK [NUM_ROWS] = '{
        '{OP_UNLOCK,  4'd0,  1'b1, '{4'd0,  ST_FAULT,   5'd0, 1'b0, 1'b1}},
        '{OP_READ,    4'd15, 1'b1, '{4'd15, ST_GRANTED, 5'd1, 1'b0, 1'b1}},
        '{OP_READ,    4'd0,  1'b1, '{4'd0,  ST_GRANTED, 5'd2, 1'b0, 1'b1}},
        '{OP_WRITE,   4'd5,  1'b1, '{4'd5,  ST_QUEUED,  5'd2, 1'b0, 1'b1}},
        '{OP_READ,    4'd9,  1'b1, '{4'd9,  ST_QUEUED,  5'd2, 1'b0, 1'b1}},
        '{OP_UNLOCK,  4'd3,  1'b1, '{4'd3,  ST_GRANTED, 5'd1, 1'b0, 1'b1}},
        '{OP_UNLOCK,  4'd3,  1'b0, '0},
        '{OP_WRITE,   4'd10, 1'b1, '{4'd10, ST_QUEUED,  5'd0, 1'b1, 1'b1}},
        '{OP_READ,    4'd1,  1'b1, '{4'd1,  ST_QUEUED,  5'd0, 1'b1, 1'b1}},
        '{OP_READ,    4'd14, 1'b1, '{4'd14, ST_QUEUED,  5'd0, 1'b1, 1'b1}},
        '{OP_UNLOCK,  4'd5,  1'b0, '0},
        '{OP_UNLOCK,  4'd10, 1'b0, '0},
        '{OP_WRITE,   4'd2,  1'b1, '{4'd2,  ST_QUEUED,  5'd3, 1'b0, 1'b1}},
        '{OP_WRITE,   4'd7,  1'b1, '{4'd7,  ST_QUEUED,  5'd3, 1'b0, 1'b1}},
        '{OP_DESTROY, 4'd8,  1'b0, '0},
        '{OP_READ,    4'd4,  1'b1, '{4'd4,  ST_GRANTED, 5'd4, 1'b0, 1'b1}},
        '{OP_UNLOCK,  4'd6,  1'b1, '{4'd6,  ST_GRANTED, 5'd3, 1'b0, 1'b1}},
        '{OP_UNLOCK,  4'd6,  1'b1, '{4'd6,  ST_GRANTED, 5'd2, 1'b0, 1'b1}},
        '{OP_UNLOCK,  4'd6,  1'b1, '{4'd6,  ST_GRANTED, 5'd1, 1'b0, 1'b1}},
        '{OP_UNLOCK,  4'd6,  1'b1, '{4'd6,  ST_GRANTED, 5'd0, 1'b0, 1'b1}},
        '{OP_UNLOCK,  4'd11, 1'b1, '{4'd11, ST_FAULT,   5'd0, 1'b0, 1'b1}},
        '{OP_WRITE,   4'd12, 1'b1, '{4'd12, ST_GRANTED, 5'd0, 1'b1, 1'b1}},
        '{OP_DESTROY, 4'd13, 1'b1, '{4'd13, ST_GRANTED, 5'd0, 1'b1, 1'b1}},
        '{OP_UNLOCK,  4'd15, 1'b1, '{4'd15, ST_GRANTED, 5'd0, 1'b0, 1'b1}}
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [OP_W-1:0]     opcode;
    logic [ID_W-1:0]     requester_id;
    logic                out_valid;
    logic                out_ready;
    logic [ID_W-1:0]     target_id;
    logic [STATUS_W-1:0] status;
    logic [READER_W-1:0] readers_now;
    logic                writer_holds;
    logic                last;

    // Behavioural copy of the lock state.
    logic [READER_W-1:0] lock_readers    = '0;
    logic                lock_write_held = 1'b0;
    logic [ID_W-1:0]     waiting_readers[$];
    logic [ID_W-1:0]     waiting_writers[$];

    // Results of the request being predicted, and all results still owed.
    lock_result_t        step_results[$];
    lock_result_t        owed_results[$];
    lock_result_t        due;

    // Hand-written issuer result of the request now on offer, if any.
    logic                row_checked;
    lock_result_t        row_ref;

    logic                tx_steady      = 1'b0;
    logic                long_hold_done = 1'b0;
    int unsigned         requests_sent  = 0;
    int unsigned         requests_taken = 0;
    int unsigned         results_seen   = 0;
    int unsigned         error_count    = 0;
    int unsigned         longest_burst  = 0;
    int unsigned         refusals       = 0;
    int unsigned         peak_readers   = 0;
    int unsigned         cycle_count    = 0;

    always #2 clk = ~clk;

    reader_writer_lock_arbiter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .requester_id (requester_id),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .target_id    (target_id),
        .status       (status),
        .readers_now  (readers_now),
        .writer_holds (writer_holds),
        .last         (last)
    );

    function automatic logic [ID_W-1:0] any_id();
        return ID_W'($urandom_range(0, NUM_REQUESTERS - 1));
    endfunction

    // Picks a read or a write request at random.
    function automatic opcode_t read_or_write();
        return ($urandom_range(0, 1) == 1) ? OP_READ : OP_WRITE;
    endfunction

    // Records one result with the lock state as it stands at that point.
    function automatic void record_result(logic [ID_W-1:0] who, status_t st);
        lock_result_t res;
        res = '{who, st, lock_readers, lock_write_held, 1'b0};
        step_results.push_back(res);
    endfunction

    // Applies one request to the lock copy and lists the results it causes.
    function automatic void apply_request(opcode_t op, logic [ID_W-1:0] id);
        logic [ID_W-1:0] who;
        lock_result_t    tail_res;
        step_results.delete();
        case (op)
            OP_READ:
            begin
                // Readers queue behind a holding or waiting writer.
                if (lock_write_held || waiting_writers.size() != 0)
                begin
                    if (waiting_readers.size() < NUM_REQUESTERS)
                    begin
                        waiting_readers.push_back(id);
                        record_result(id, ST_QUEUED);
                    end
                    else
                    begin
                        record_result(id, ST_FAULT);
                    end
                end
                else if (lock_readers >= READER_TOP)
                begin
                    record_result(id, ST_FAULT);
                end
                else
                begin
                    lock_readers = lock_readers + 1'b1;
                    record_result(id, ST_GRANTED);
                end
            end
            OP_WRITE:
            begin
                // A writer waits while the lock is held in either mode.
                if (lock_write_held || lock_readers != '0)
                begin
                    if (waiting_writers.size() < NUM_REQUESTERS)
                    begin
                        waiting_writers.push_back(id);
                        record_result(id, ST_QUEUED);
                    end
                    else
                    begin
                        record_result(id, ST_FAULT);
                    end
                end
                else
                begin
                    lock_write_held = 1'b1;
                    record_result(id, ST_GRANTED);
                end
            end
            OP_UNLOCK:
            begin
                if (lock_write_held)
                begin
                    if (waiting_writers.size() != 0)
                    begin
                        // The head writer takes over; the lock stays exclusive.
                        who = waiting_writers.pop_front();
                        record_result(id, ST_GRANTED);
                        record_result(who, ST_GRANTED);
                    end
                    else
                    begin
                        // No writer waits, so every queued reader gets in.
                        lock_write_held = 1'b0;
                        record_result(id, ST_GRANTED);
                        while (waiting_readers.size() != 0)
                        begin
                            who = waiting_readers.pop_front();
                            if (lock_readers < READER_TOP)
                            begin
                                lock_readers = lock_readers + 1'b1;
                            end
                            record_result(who, ST_GRANTED);
                        end
                    end
                end
                else if (lock_readers != '0)
                begin
                    // The last reader out hands the lock to the head writer.
                    lock_readers = lock_readers - 1'b1;
                    record_result(id, ST_GRANTED);
                    if (lock_readers == '0 && waiting_writers.size() != 0)
                    begin
                        who = waiting_writers.pop_front();
                        lock_write_held = 1'b1;
                        record_result(who, ST_GRANTED);
                    end
                end
                else
                begin
                    record_result(id, ST_FAULT);
                end
            end
            default:
            begin
                // Destroy releases queued readers first, then queued writers.
                record_result(id, ST_GRANTED);
                while (waiting_readers.size() != 0)
                begin
                    who = waiting_readers.pop_front();
                    record_result(who, ST_RELEASED);
                end
                while (waiting_writers.size() != 0)
                begin
                    who = waiting_writers.pop_front();
                    record_result(who, ST_RELEASED);
                end
            end
        endcase
        tail_res = step_results.pop_back();
        tail_res.fin = 1'b1;
        step_results.push_back(tail_res);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // Request and result transfers are observed on the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                requests_taken++;
                apply_request(opcode_t'(opcode), requester_id);
                if (row_checked)
                begin
                    step_results[0] = row_ref;
                end
                if (step_results.size() > longest_burst)
                begin
                    longest_burst = step_results.size();
                end
                foreach (step_results[i])
                begin
                    if (step_results[i].st == ST_FAULT)
                    begin
                        refusals++;
                    end
                    if (step_results[i].readers > peak_readers)
                    begin
                        peak_readers = step_results[i].readers;
                    end
                    owed_results.push_back(step_results[i]);
                end
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (owed_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result for requester %0d with none expected, status %0d",
                             $time, target_id, status);
                end
                else
                begin
                    due = owed_results.pop_front();
                    check_field("target_id", due.target, target_id);
                    check_field("status", due.st, status);
                    check_field("readers_now", due.readers, readers_now);
                    check_field("writer_holds", due.held, writer_holds);
                    check_field("last", due.fin, last);
                end
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run stopped after %0d cycles", $time, CYCLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: random stalls, with one long hold-off once traffic is flowing.
    initial
    begin : result_sink
        int stall;
        int roll;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            roll = $urandom_range(0, 19);
            if (!long_hold_done && results_seen >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                stall = LONG_HOLD;
            end
            else if (roll < 11)
            begin
                stall = 0;
            end
            else if (roll < 18)
            begin
                stall = $urandom_range(1, 3);
            end
            else
            begin
                stall = $urandom_range(10, 30);
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(0, 12)) @(negedge clk);
        end
    end

    // Offers one request from a falling edge and returns at the falling edge
    // after its transfer, when the lock copy already reflects it.
    task automatic drive_request(input opcode_t op, input logic [ID_W-1:0] id);
        int gap;
        int roll;
        roll = $urandom_range(0, 19);
        if (tx_steady || roll < 10)
        begin
            gap = 0;
        end
        else if (roll < 18)
        begin
            gap = $urandom_range(1, 3);
        end
        else
        begin
            gap = $urandom_range(8, 30);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        requester_id <= id;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        requests_sent++;
    endtask

    initial
    begin : stimulus
        int idx;
        int writes_sent;
        int reads_sent;
        int n;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        opcode       = OP_READ;
        requester_id = '0;
        row_checked  = 1'b0;
        row_ref      = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed walk through the table.
        for (idx = 0; idx < NUM_ROWS; idx++)
        begin
            row_checked = LOCK_WALK[idx].typed;
            row_ref     = LOCK_WALK[idx].want;
            drive_request(LOCK_WALK[idx].op, LOCK_WALK[idx].id);
        end
        row_checked = 1'b0;

        // Random episodes of lock traffic.
        while (requests_sent < NUM_ROWS + RANDOM_ITEMS)
        begin
            tx_steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0:
                begin
                    // Unstructured requests.
                    n = $urandom_range(1, 6);
                    repeat (n) drive_request(opcode_t'($urandom_range(0, 3)), any_id());
                end
                1:
                begin
                    // Shared phase, perhaps with a writer queueing behind it.
                    n = $urandom_range(1, 6);
                    repeat (n) drive_request(OP_READ, any_id());
                    if ($urandom_range(0, 1) == 1)
                    begin
                        drive_request(OP_WRITE, any_id());
                    end
                    repeat (n + $urandom_range(0, 1)) drive_request(OP_UNLOCK, any_id());
                end
                2:
                begin
                    // Exclusive phase with contenders of both kinds.
                    drive_request(OP_WRITE, any_id());
                    repeat ($urandom_range(1, 4))
                        drive_request(read_or_write(), any_id());
                    repeat ($urandom_range(1, 5)) drive_request(OP_UNLOCK, any_id());
                end
                default:
                begin
                    // Contention cut short by destroy.
                    drive_request(OP_WRITE, any_id());
                    repeat ($urandom_range(2, 6))
                        drive_request(read_or_write(), any_id());
                    drive_request(OP_DESTROY, any_id());
                    drive_request(OP_UNLOCK, any_id());
                end
            endcase
        end

        // Free the lock completely.
        tx_steady = 1'b0;
        while (lock_readers != '0 || lock_write_held)
            drive_request(OP_UNLOCK, any_id());

        // Hold the lock for writing and overflow both queues, then destroy
        // so that one request releases every waiter.
        drive_request(OP_WRITE, any_id());
        writes_sent = 0;
        reads_sent  = 0;
        while (writes_sent <= NUM_REQUESTERS || reads_sent <= NUM_REQUESTERS)
        begin
            if (reads_sent > NUM_REQUESTERS
                || (writes_sent <= NUM_REQUESTERS && $urandom_range(0, 1) == 1))
            begin
                drive_request(OP_WRITE, any_id());
                writes_sent++;
            end
            else
            begin
                drive_request(OP_READ, any_id());
                reads_sent++;
            end
        end
        drive_request(OP_DESTROY, any_id());
        drive_request(OP_UNLOCK, any_id());

        // Pile readers past the count ceiling, then queue a writer behind them.
        tx_steady = 1'b1;
        repeat (int'(READER_TOP) + 2) drive_request(OP_READ, any_id());
        tx_steady = 1'b0;
        drive_request(OP_WRITE, any_id());
        repeat (3) drive_request(OP_UNLOCK, any_id());
        in_valid <= 1'b0;

        // Wait for every owed result, then allow stray results to show up.
        while (owed_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d requests and %0d result transfers, %0d of them refusals.",
                 requests_taken, results_seen, refusals);
        $display("Longest burst %0d results from one request; reader count peaked at %0d.",
                 longest_burst, peak_readers);
        if (error_count == 0 && owed_results.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
